// ----- design/mtoc_pkg.sv -----
`default_nettype none

package mtoc_pkg;

	// field widths
	localparam int TS_W    = 64;
	localparam int PRICE_W = 16;
	localparam int SEC_W   = 35;
	localparam int LVL_W   = 2;
	localparam int LEVELS  = 4;

	// nanoseconds to seconds: 1e9 = 2^9 * 1953125
	localparam int NS_SHIFT = 9;
	localparam int NS_DEN   = 1953125;
	localparam int NS_NUM_W = TS_W - NS_SHIFT;

	// timeframe spans in seconds
	localparam int SECS_PER_MIN  = 60;
	localparam int MINS_PER_HOUR = 60;
	localparam int HOURS_PER_DAY = 24;
	localparam int SECS_PER_HOUR = SECS_PER_MIN * MINS_PER_HOUR;
	localparam int SECS_PER_DAY  = SECS_PER_HOUR * HOURS_PER_DAY;

	// quotient widths of the seconds dividers
	localparam int MIN_Q_W  = SEC_W - $clog2(SECS_PER_MIN) + 1;
	localparam int HOUR_Q_W = SEC_W - $clog2(SECS_PER_HOUR) + 1;
	localparam int DAY_Q_W  = SEC_W - $clog2(SECS_PER_DAY) + 1;

	// level codes
	localparam logic [LVL_W-1:0] LVL_SECOND = 2'd0;
	localparam logic [LVL_W-1:0] LVL_MINUTE = 2'd1;
	localparam logic [LVL_W-1:0] LVL_HOUR   = 2'd2;
	localparam logic [LVL_W-1:0] LVL_DAY    = 2'd3;

	// classified trade handed from front to back
	typedef struct packed {
		logic                                first;
		logic [LEVELS-1:0]                   adv;
		logic [PRICE_W-1:0]                  price;
		logic [LEVELS-1:0][SEC_W-1:0]        start;
	} entry_t;

	// one closed candle
	typedef struct packed {
		logic [LVL_W-1:0]   level;
		logic [SEC_W-1:0]   start;
		logic [PRICE_W-1:0] open_p;
		logic [PRICE_W-1:0] high_p;
		logic [PRICE_W-1:0] low_p;
		logic [PRICE_W-1:0] close_p;
		logic               last;
	} result_t;

endpackage

`default_nettype wire

// ----- design/multi_timeframe_ohlc_candles_unit.sv -----
// Multi-timeframe candle builder (second, minute, hour, day).
// Slave stream: one trade per request, s_tdata = timestamp (ns) and price.
// Master stream: one closed candle per request, m_tuser = level,
// m_tlast marks the final candle caused by one trade.
// Throughput: one trade per cycle while the queue has room. A trade that closes
// k candles holds the back end until all k are sent, one candle per cycle
// through the output register while the receiver is ready.
// The front end spends 7 stages converting nanoseconds to seconds and 6 more
// splitting seconds into minute, hour and day periods, then the trade passes
// through the queue write and the output register.
// A queue of QUEUE_DEPTH trades parts the front end from the back end, so
// trades keep flowing while a burst of candles drains.
// When the receiver stalls, the output register holds its candle, the
// queue fills and then s_tready drops, stalling the whole front pipeline.
// Reset clears all candles and the period state; the first trade after
// reset opens every level and emits nothing.
`default_nettype none

module multi_timeframe_ohlc_candles_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [63:0] timestamp_ns, [79:64] price
	input  wire logic [79:0]  s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [34:0] period_start_s, [50:35] open_price, [66:51] high_price,
	// [82:67] low_price, [98:83] close_price, [103:99] zero
	output logic      [103:0] m_tdata,
	// [1:0] level
	output logic      [1:0]   m_tuser,
	output logic              m_tlast
);

	localparam int ENTRY_W = $bits(mtoc_pkg::entry_t);

	logic              push;
	logic              full;
	logic              pop;
	logic              not_empty;
	mtoc_pkg::entry_t  f_entry;
	mtoc_pkg::entry_t  b_entry;
	logic [ENTRY_W-1:0] q_dout;
	mtoc_pkg::result_t res;

	// front end: time conversion and classification
	mtoc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.ts      (s_tdata[63:0]),
		.price   (s_tdata[79:64]),
		.full    (full),
		.push    (push),
		.entry   (f_entry)
	);

	// request queue
	mtoc_fifo #(
		.W    (ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (f_entry),
		.full     (full),
		.pop      (pop),
		.not_empty(not_empty),
		.dout     (q_dout)
	);

	assign b_entry = mtoc_pkg::entry_t'(q_dout);

	// back end: candle state and emission
	mtoc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (not_empty),
		.q_entry  (b_entry),
		.q_pop    (pop),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res      (res)
	);

	assign m_tdata = {5'b0, res.close_p, res.low_p, res.high_p, res.open_p, res.start};
	assign m_tuser = res.level;
	assign m_tlast = res.last;

endmodule

`default_nettype wire

// ----- design/mtoc_cdiv.sv -----
`default_nettype none

// pipelined restoring divider by a constant, ceil(Q_W/STAGES) quotient bits per stage
module mtoc_cdiv #(
	parameter int NUM_W  = 35,
	parameter int Q_W    = 30,
	parameter int DEN    = 60,
	parameter int STAGES = 6
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic [NUM_W-1:0]         num,
	output logic      [Q_W-1:0]           quo,
	output logic      [$clog2(DEN)-1:0]   rem
);

	localparam int R_W   = $clog2(DEN);
	localparam int STEPS = (Q_W + STAGES - 1) / STAGES;

	logic [R_W-1:0] rem_in;
	logic [Q_W-1:0] wrk_in;
	logic [R_W-1:0] rem_s [STAGES];
	logic [Q_W-1:0] wrk_s [STAGES];

	// top bits start as the partial remainder, low bits shift through
	assign rem_in = R_W'(num >> Q_W);
	assign wrk_in = num[Q_W-1:0];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [R_W-1:0] rem_src;
		logic [Q_W-1:0] wrk_src;
		logic [R_W-1:0] rem_d;
		logic [Q_W-1:0] wrk_d;

		if (g == 0) begin : g_first
			assign rem_src = rem_in;
			assign wrk_src = wrk_in;
		end else begin : g_next
			assign rem_src = rem_s[g-1];
			assign wrk_src = wrk_s[g-1];
		end

		// compare and subtract once per quotient bit
		always_comb begin
			logic [R_W:0] t;
			rem_d = rem_src;
			wrk_d = wrk_src;
			t = '0;
			for (int k = 0; k < STEPS; k++) begin
				if (g * STEPS + k < Q_W) begin
					t = {rem_d, wrk_d[Q_W-1]};
					if (t >= (R_W+1)'(DEN)) begin
						rem_d = R_W'(t - (R_W+1)'(DEN));
						wrk_d = {wrk_d[Q_W-2:0], 1'b1};
					end else begin
						rem_d = R_W'(t);
						wrk_d = {wrk_d[Q_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= rem_d;
				wrk_s[g] <= wrk_d;
			end
		end
	end

	assign quo = wrk_s[STAGES-1];
	assign rem = rem_s[STAGES-1];

endmodule

`default_nettype wire

// ----- design/mtoc_front.sv -----
`default_nettype none

// front: time conversion pipeline and period classification
module mtoc_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [mtoc_pkg::TS_W-1:0]    ts,
	input  wire logic [mtoc_pkg::PRICE_W-1:0] price,
	input  wire logic                         full,
	output logic                              push,
	output mtoc_pkg::entry_t                  entry
);

	localparam int NS_STG  = 7;
	localparam int SEC_STG = 6;
	localparam int TOT_STG = NS_STG + SEC_STG;
	localparam int SEC_W   = mtoc_pkg::SEC_W;
	localparam int LEVELS  = mtoc_pkg::LEVELS;
	localparam int RM_W    = $clog2(mtoc_pkg::SECS_PER_MIN);
	localparam int RH_W    = $clog2(mtoc_pkg::SECS_PER_HOUR);
	localparam int RD_W    = $clog2(mtoc_pkg::SECS_PER_DAY);

	logic                        en;
	logic [TOT_STG-1:0]          vld_q;
	logic [mtoc_pkg::PRICE_W-1:0] prc_s [TOT_STG];
	logic [SEC_W-1:0]            sec_s [SEC_STG];
	logic [SEC_W-1:0]            ns_sec;
	logic [$clog2(mtoc_pkg::NS_DEN)-1:0] ns_rem;
	logic [mtoc_pkg::MIN_Q_W-1:0]  min_quo;
	logic [mtoc_pkg::HOUR_Q_W-1:0] hour_quo;
	logic [mtoc_pkg::DAY_Q_W-1:0]  day_quo;
	logic [RM_W-1:0]             rem_min;
	logic [RH_W-1:0]             rem_hour;
	logic [RD_W-1:0]             rem_day;
	logic [LEVELS-1:0][SEC_W-1:0] new_start;
	logic [LEVELS-1:0][SEC_W-1:0] start_q;
	logic                        have_q;
	logic                        later;
	logic [LEVELS-1:0]           adv;

	// whole pipeline stalls together when the queue is full and the last stage holds a trade
	assign en       = ~vld_q[TOT_STG-1] | ~full;
	assign in_ready = en;
	assign push     = vld_q[TOT_STG-1] & en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOT_STG-2:0], in_valid};
		end
	end

	// price and seconds ride alongside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			prc_s[0] <= price;
			for (int i = 1; i < TOT_STG; i++) prc_s[i] <= prc_s[i-1];
			sec_s[0] <= ns_sec;
			for (int i = 1; i < SEC_STG; i++) sec_s[i] <= sec_s[i-1];
		end
	end

	// nanoseconds to whole seconds
	mtoc_cdiv #(
		.NUM_W (mtoc_pkg::NS_NUM_W),
		.Q_W   (SEC_W),
		.DEN   (mtoc_pkg::NS_DEN),
		.STAGES(NS_STG)
	) u_ns_div (
		.clk(clk),
		.en (en),
		.num(ts[mtoc_pkg::TS_W-1:mtoc_pkg::NS_SHIFT]),
		.quo(ns_sec),
		.rem(ns_rem)
	);

	// seconds into minute, hour and day remainders
	mtoc_cdiv #(
		.NUM_W (SEC_W),
		.Q_W   (mtoc_pkg::MIN_Q_W),
		.DEN   (mtoc_pkg::SECS_PER_MIN),
		.STAGES(SEC_STG)
	) u_min_div (
		.clk(clk),
		.en (en),
		.num(ns_sec),
		.quo(min_quo),
		.rem(rem_min)
	);

	mtoc_cdiv #(
		.NUM_W (SEC_W),
		.Q_W   (mtoc_pkg::HOUR_Q_W),
		.DEN   (mtoc_pkg::SECS_PER_HOUR),
		.STAGES(SEC_STG)
	) u_hour_div (
		.clk(clk),
		.en (en),
		.num(ns_sec),
		.quo(hour_quo),
		.rem(rem_hour)
	);

	mtoc_cdiv #(
		.NUM_W (SEC_W),
		.Q_W   (mtoc_pkg::DAY_Q_W),
		.DEN   (mtoc_pkg::SECS_PER_DAY),
		.STAGES(SEC_STG)
	) u_day_div (
		.clk(clk),
		.en (en),
		.num(ns_sec),
		.quo(day_quo),
		.rem(rem_day)
	);

	// period starts of the trade at each level
	always_comb begin
		new_start[0] = sec_s[SEC_STG-1];
		new_start[1] = sec_s[SEC_STG-1] - SEC_W'(rem_min);
		new_start[2] = sec_s[SEC_STG-1] - SEC_W'(rem_hour);
		new_start[3] = sec_s[SEC_STG-1] - SEC_W'(rem_day);
	end

	// a later second closes every level whose period start moved
	always_comb begin
		later  = have_q & (new_start[0] > start_q[0]);
		adv[0] = later;
		for (int l = 1; l < LEVELS; l++) adv[l] = later & (new_start[l] > start_q[l]);
	end

	always_comb begin
		entry.first = ~have_q;
		entry.adv   = adv;
		entry.price = prc_s[TOT_STG-1];
		entry.start = start_q;
	end

	// current period starts; late and same-second trades leave them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			start_q <= '0;
		end else if (push) begin
			have_q <= 1'b1;
			if (!have_q || later) start_q <= new_start;
		end
	end

endmodule

`default_nettype wire

// ----- design/mtoc_fifo.sv -----
`default_nettype none

// short request queue between front and back
module mtoc_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] din,
	output logic              full,
	input  wire logic         pop,
	output logic              not_empty,
	output logic [W-1:0]      dout
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push & ~full;
	assign do_pop    = pop & not_empty;
	assign dout      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= din;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- design/mtoc_back.sv -----
`default_nettype none

// back: candle state, emits closed candles one per cycle while the output slot is free
module mtoc_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire mtoc_pkg::entry_t q_entry,
	output logic                  q_pop,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output mtoc_pkg::result_t     res
);

	localparam int LEVELS  = mtoc_pkg::LEVELS;
	localparam int PRICE_W = mtoc_pkg::PRICE_W;

	logic [PRICE_W-1:0] open_q  [LEVELS];
	logic [PRICE_W-1:0] high_q  [LEVELS];
	logic [PRICE_W-1:0] low_q   [LEVELS];
	logic [PRICE_W-1:0] close_q [LEVELS];
	logic [LEVELS-1:0]  done_q;
	logic               res_valid_q;
	mtoc_pkg::result_t  res_q;

	logic [LEVELS-1:0]         pend;
	logic [LEVELS-1:0]         sel_bit;
	logic [mtoc_pkg::LVL_W-1:0] sel_lvl;
	logic                      is_last;
	logic                      slot_free;
	logic                      emit;
	logic                      finish;

	// lowest level still to be emitted for this trade
	always_comb begin
		pend = q_entry.adv & ~done_q;
		priority if (pend[0]) begin
			sel_lvl = mtoc_pkg::LVL_SECOND;
			sel_bit = 4'b0001;
		end else if (pend[1]) begin
			sel_lvl = mtoc_pkg::LVL_MINUTE;
			sel_bit = 4'b0010;
		end else if (pend[2]) begin
			sel_lvl = mtoc_pkg::LVL_HOUR;
			sel_bit = 4'b0100;
		end else begin
			sel_lvl = mtoc_pkg::LVL_DAY;
			sel_bit = 4'b1000;
		end
		is_last = ((pend & ~sel_bit) == '0);
	end

	assign slot_free = ~res_valid_q | res_ready;
	assign emit      = q_valid & (pend != '0) & slot_free;
	assign finish    = q_valid & ((pend == '0) | (emit & is_last));
	assign q_pop     = finish;

	// output register and progress through the trade
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			done_q      <= '0;
		end else begin
			if (emit) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			if (finish) done_q <= '0;
			else if (emit) done_q <= done_q | sel_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.level   <= sel_lvl;
			res_q.start   <= q_entry.start[sel_lvl];
			res_q.open_p  <= open_q[sel_lvl];
			res_q.high_p  <= high_q[sel_lvl];
			res_q.low_p   <= low_q[sel_lvl];
			res_q.close_p <= close_q[sel_lvl];
			res_q.last    <= is_last;
		end
	end

	// candle update once the trade is done with
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				open_q[l]  <= '0;
				high_q[l]  <= '0;
				low_q[l]   <= '0;
				close_q[l] <= '0;
			end
		end else if (finish) begin
			for (int l = 0; l < LEVELS; l++) begin
				if (q_entry.first || q_entry.adv[l]) begin
					open_q[l] <= q_entry.price;
					high_q[l] <= q_entry.price;
					low_q[l]  <= q_entry.price;
				end else begin
					if (q_entry.price > high_q[l]) high_q[l] <= q_entry.price;
					if (q_entry.price < low_q[l]) low_q[l] <= q_entry.price;
				end
				close_q[l] <= q_entry.price;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ----- verif/multi_timeframe_ohlc_candles_unit_tb.sv -----
`timescale 1ns / 1ps

module multi_timeframe_ohlc_candles_unit_tb;

	localparam logic [63:0] NS_PER_SEC = 64'd1_000_000_000;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_PATTERN,
		READY_RANDOM,
		READY_LONG_STALL
	} ready_mode_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [79:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	// predicted candle state
	logic                          seen_trade;
	logic [mtoc_pkg::SEC_W-1:0]    cur_second;
	logic [mtoc_pkg::PRICE_W-1:0]  c_open  [mtoc_pkg::LEVELS];
	logic [mtoc_pkg::PRICE_W-1:0]  c_high  [mtoc_pkg::LEVELS];
	logic [mtoc_pkg::PRICE_W-1:0]  c_low   [mtoc_pkg::LEVELS];
	logic [mtoc_pkg::PRICE_W-1:0]  c_close [mtoc_pkg::LEVELS];
	mtoc_pkg::result_t             pending_candles [$];

	int          errors = 0;
	int          burst_left = 0;
	int          ready_left = 0;
	ready_mode_t ready_mode = READY_ALWAYS;
	logic [31:0] ready_pat = '0;
	logic [63:0] trade_sec;

	multi_timeframe_ohlc_candles_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// timeframe length in seconds
	function automatic logic [63:0] level_span(input int lv);
		case (lv[mtoc_pkg::LVL_W-1:0])
			mtoc_pkg::LVL_SECOND: return 64'd1;
			mtoc_pkg::LVL_MINUTE: return 64'(mtoc_pkg::SECS_PER_MIN);
			mtoc_pkg::LVL_HOUR:   return 64'(mtoc_pkg::SECS_PER_HOUR);
			default:              return 64'(mtoc_pkg::SECS_PER_DAY);
		endcase
	endfunction

	function automatic logic [63:0] make_ts(input logic [63:0] sec, input logic [31:0] frac);
		return sec * NS_PER_SEC + 64'(frac);
	endfunction

	function automatic logic [mtoc_pkg::PRICE_W-1:0] rand_price();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return (mtoc_pkg::PRICE_W)'($urandom);
	endfunction

	// fold one trade into the candles and queue any candles it closes
	task automatic update_candles(input logic [63:0] ts,
			input logic [mtoc_pkg::PRICE_W-1:0] px);
		logic [63:0]       now_s;
		logic [63:0]       span;
		logic [63:0]       old_idx;
		mtoc_pkg::result_t closed [mtoc_pkg::LEVELS];
		int                n;
		n = 0;
		now_s = ts / NS_PER_SEC;
		if (!seen_trade) begin
			seen_trade = 1'b1;
			cur_second = now_s[mtoc_pkg::SEC_W-1:0];
			for (int i = 0; i < mtoc_pkg::LEVELS; i++) begin
				c_open[i] = px; c_high[i] = px; c_low[i] = px; c_close[i] = px;
			end
		end else if (now_s <= 64'(cur_second)) begin
			for (int i = 0; i < mtoc_pkg::LEVELS; i++) begin
				if (px > c_high[i]) c_high[i] = px;
				if (px < c_low[i]) c_low[i] = px;
				c_close[i] = px;
			end
		end else begin
			for (int i = 0; i < mtoc_pkg::LEVELS; i++) begin
				span = level_span(i);
				old_idx = 64'(cur_second) / span;
				if (now_s / span > old_idx) begin
					closed[n].level   = i[mtoc_pkg::LVL_W-1:0];
					closed[n].start   = (mtoc_pkg::SEC_W)'(old_idx * span);
					closed[n].open_p  = c_open[i];
					closed[n].high_p  = c_high[i];
					closed[n].low_p   = c_low[i];
					closed[n].close_p = c_close[i];
					closed[n].last    = 1'b0;
					n++;
					c_open[i] = px; c_high[i] = px; c_low[i] = px; c_close[i] = px;
				end else begin
					if (px > c_high[i]) c_high[i] = px;
					if (px < c_low[i]) c_low[i] = px;
					c_close[i] = px;
				end
			end
			if (n > 0)
				closed[n-1].last = 1'b1;
			for (int k = 0; k < n; k++)
				pending_candles.push_back(closed[k]);
			cur_second = now_s[mtoc_pkg::SEC_W-1:0];
		end
	endtask

	// send one trade request, called and returning at a falling edge
	task automatic send_trade(input logic [63:0] ts, input logic [mtoc_pkg::PRICE_W-1:0] px);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {px, ts};
		do @(posedge clk); while (!s_tready);
		update_candles(ts, px);
		@(negedge clk);
		// bursts of back-to-back requests with random gaps
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// receiver stall patterns
	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			ready_pat  = $urandom;
			ready_left = $urandom_range(20, 80);
		end
		ready_left--;
		case (ready_mode)
			READY_ALWAYS:  m_tready <= 1'b1;
			READY_PATTERN: m_tready <= ready_pat[ready_left % 32];
			READY_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
			default:       m_tready <= ((ready_left % 24) < 3);
		endcase
	end

	task automatic check_field(input string name, input logic [63:0] expv, input logic [63:0] actv);
		if (expv !== actv) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
		end
	endtask

	// compare each accepted candle with the oldest prediction
	always @(posedge clk) begin
		mtoc_pkg::result_t exp_c;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_candles.size() == 0) begin
				errors++;
				$display("%0t: unexpected candle, expected none, actual level %0d start %0d",
					$time, m_tuser, m_tdata[34:0]);
			end else begin
				exp_c = pending_candles.pop_front();
				check_field("level", 64'(exp_c.level), 64'(m_tuser));
				check_field("period_start_s", 64'(exp_c.start), 64'(m_tdata[34:0]));
				check_field("open_price", 64'(exp_c.open_p), 64'(m_tdata[50:35]));
				check_field("high_price", 64'(exp_c.high_p), 64'(m_tdata[66:51]));
				check_field("low_price", 64'(exp_c.low_p), 64'(m_tdata[82:67]));
				check_field("close_price", 64'(exp_c.close_p), 64'(m_tdata[98:83]));
				check_field("last_of_run", 64'(exp_c.last), 64'(m_tlast));
			end
		end
	end

	// first trade opens every level at time zero
	task automatic test_first_trade();
		send_trade(make_ts(64'd0, 32'd0), 16'h8000);
	endtask

	// trades in the current second only widen the candles
	task automatic test_same_second();
		send_trade(make_ts(64'd0, 32'd999_999_999), 16'hFFFF);
		send_trade(make_ts(64'd0, 32'd1), 16'h0000);
		send_trade(make_ts(64'd0, 32'd500), 16'h1234);
	endtask

	// second, minute, hour and day boundaries
	task automatic test_period_closes();
		send_trade(make_ts(64'd1, 32'd0), 16'h5555);
		send_trade(make_ts(64'd59, 32'd999_999_999), 16'hAAAA);
		send_trade(make_ts(64'd60, 32'd0), 16'h0F0F);
		send_trade(make_ts(64'd61, 32'd7), 16'hF0F0);
		send_trade(make_ts(64'd3599, 32'd123), 16'h00FF);
		send_trade(make_ts(64'd3600, 32'd0), 16'hFF00);
		send_trade(make_ts(64'd3661, 32'd42), 16'h7FFF);
		send_trade(make_ts(64'd86399, 32'd999_999_999), 16'h0001);
		send_trade(make_ts(64'd86400, 32'd0), 16'hFFFE);
		// jump across several days at once
		send_trade(make_ts(64'd277_217, 32'd314), 16'h4321);
	endtask

	// an earlier second is taken as in-period
	task automatic test_late_trade();
		send_trade(make_ts(64'd100, 32'd0), 16'hFFFF);
		send_trade(make_ts(64'd277_217, 32'd900), 16'h0000);
		send_trade(make_ts(64'd277_218, 32'd0), 16'h2222);
	endtask

	// mostly advancing time with random steps, some late trades
	task automatic test_random_trades();
		int          r;
		logic [63:0] sec;
		trade_sec = 64'd1_000_000 + 64'($urandom_range(0, 1 << 30));
		for (int n = 0; n < 250; n++) begin
			r = $urandom_range(0, 99);
			sec = trade_sec;
			if (r < 35) begin
				sec = trade_sec;
			end else if (r < 55) begin
				trade_sec += 1;
			end else if (r < 70) begin
				trade_sec += 64'($urandom_range(2, 59));
			end else if (r < 78) begin
				trade_sec = (trade_sec / 60 + 1) * 60 + 64'($urandom_range(0, 2));
			end else if (r < 84) begin
				trade_sec = (trade_sec / mtoc_pkg::SECS_PER_HOUR + 1) * mtoc_pkg::SECS_PER_HOUR;
			end else if (r < 88) begin
				trade_sec = (trade_sec / mtoc_pkg::SECS_PER_DAY + 1) * mtoc_pkg::SECS_PER_DAY
					+ 64'($urandom_range(0, 1));
			end else if (r < 92) begin
				trade_sec += 64'($urandom_range(1, 1 << 20));
			end
			if (r >= 92 && r < 97)
				sec = trade_sec - 64'($urandom_range(1, 100));
			else
				sec = trade_sec;
			if (r >= 97)
				send_trade(make_ts(sec, (r == 97) ? 32'd0 : 32'd999_999_999), rand_price());
			else
				send_trade(make_ts(sec, 32'($urandom_range(0, 999_999_999))), rand_price());
		end
	endtask

	// near 2^63 ns and at the top of the timestamp range, then a late trade
	task automatic test_timestamp_extremes();
		send_trade(make_ts(64'd9_223_372_036, 32'd999_999_999), 16'hC3A5);
		send_trade(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
		send_trade(64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);
		send_trade(make_ts(64'd9_223_372_036, 32'd0), 16'h5A3C);
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		seen_trade = 1'b0;
		cur_second = '0;
		for (int i = 0; i < mtoc_pkg::LEVELS; i++) begin
			c_open[i] = '0; c_high[i] = '0; c_low[i] = '0; c_close[i] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_first_trade();
		test_same_second();
		test_period_closes();
		test_late_trade();
		test_random_trades();
		test_timestamp_extremes();
		s_tvalid <= 1'b0;

		// drain, then allow for the pipeline latency
		while (pending_candles.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("multi_timeframe_ohlc_candles_unit_tb: done, clean");
		else
			$display("multi_timeframe_ohlc_candles_unit_tb: done, errors");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("multi_timeframe_ohlc_candles_unit_tb: done, errors");
		$finish;
	end

endmodule
